// ----- design/csq_pkg.sv -----
// ----------------------------------------------------------------------------
// csq_pkg
// Shared types and constants for the counting semaphore with wait queue.
// ----------------------------------------------------------------------------
package csq_pkg;

    localparam int DEF_WAIT_DEPTH = 16;

    localparam int ACT_W  = 2;
    localparam int ID_W   = 8;
    localparam int INIT_W = 15;
    localparam int STAT_W = 3;
    localparam int CNT_W  = 17;

    localparam logic signed [CNT_W-1:0] COUNT_MAX = 17'sd65535;
    localparam logic signed [CNT_W-1:0] COUNT_ONE = 17'sd1;

    typedef enum logic [ACT_W-1:0] {
        ACT_CREATE  = 2'd0,
        ACT_DOWN    = 2'd1,
        ACT_UP      = 2'd2,
        ACT_DESTROY = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_BLOCKED  = 3'd1,
        ST_WOKEN    = 3'd2,
        ST_INACTIVE = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DRAIN
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_item;
        logic exec;
        logic drain;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic destroy_more;
        logic drain_last;
        logic queue_empty;
    } dp_stat_t;

endpackage

// ----- design/csq_ctrl.sv -----
// ----------------------------------------------------------------------------
// csq_ctrl
// Sequencer: takes a word, runs its action, then drains waiters on destroy.
// ----------------------------------------------------------------------------
module csq_ctrl
    import csq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.destroy_more ? S_DRAIN : S_IDLE;
                end
            end
            S_DRAIN:
            begin
                if (stat.out_free && stat.drain_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd.take_item = 1'b0;
        cmd.exec      = 1'b0;
        cmd.drain     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.take_item = in_valid;
            end
            S_EXEC:
            begin
                cmd.exec = stat.out_free;
            end
            S_DRAIN:
            begin
                cmd.drain = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- design/csq_dp.sv -----
// ----------------------------------------------------------------------------
// csq_dp
// Datapath: count, active flag, wait queue memory and the result register.
// ----------------------------------------------------------------------------
module csq_dp
    import csq_pkg::*;
#(
    parameter int WAIT_DEPTH = DEF_WAIT_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    output dp_stat_t          stat,
    input  logic [ACT_W-1:0]  action,
    input  logic [ID_W-1:0]   task_id,
    input  logic [INIT_W-1:0] init_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [STAT_W-1:0] status,
    output logic [ID_W-1:0]   woken_id,
    output logic              last
);

    localparam int PTR_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int WCNT_W = $clog2(WAIT_DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_END = PTR_W'(WAIT_DEPTH - 1);
    localparam logic [WCNT_W-1:0] W_FULL  = WCNT_W'(WAIT_DEPTH);
    localparam logic [WCNT_W-1:0] W_ONE   = WCNT_W'(1);

    // Latched input word.
    logic [ACT_W-1:0]  action_reg;
    logic [ID_W-1:0]   task_id_reg;
    logic [INIT_W-1:0] init_value_reg;

    // Semaphore state.
    logic signed [CNT_W-1:0] count_reg, count_next;
    logic                    active_reg, active_next;
    logic [PTR_W-1:0]        head_reg, head_next;
    logic [PTR_W-1:0]        tail_reg, tail_next;
    logic [WCNT_W-1:0]       waiters_reg, waiters_next;

    // Result register.
    logic                    out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]       status_reg, status_next;
    logic [ID_W-1:0]         woken_id_reg, woken_id_next;
    logic                    last_reg, last_next;

    // Wait queue memory; the read port always tracks the next head.
    logic [ID_W-1:0]         wait_mem [WAIT_DEPTH];
    logic [ID_W-1:0]         rd_data_reg;
    logic                    wr_en;

    logic signed [CNT_W-1:0] count_up;
    logic                    count_le0;
    logic                    up_le0;
    logic                    q_empty;
    logic                    q_full;
    logic                    load;
    logic [PTR_W-1:0]        head_inc;
    logic [PTR_W-1:0]        tail_inc;

    assign q_empty   = (waiters_reg == '0);
    assign q_full    = (waiters_reg == W_FULL);
    assign count_le0 = count_reg[CNT_W-1] || (count_reg == '0);
    assign count_up  = (count_reg < COUNT_MAX) ? (count_reg + COUNT_ONE) : count_reg;
    assign up_le0    = count_up[CNT_W-1] || (count_up == '0);
    assign head_inc  = (head_reg == PTR_END) ? '0 : (head_reg + PTR_W'(1));
    assign tail_inc  = (tail_reg == PTR_END) ? '0 : (tail_reg + PTR_W'(1));

    assign stat.out_free     = !out_valid_reg || out_ready;
    assign stat.destroy_more = (action_reg == ACT_DESTROY) && active_reg && !q_empty;
    assign stat.drain_last   = (waiters_reg == W_ONE);
    assign stat.queue_empty  = q_empty;

    always_comb
    begin
        count_next    = count_reg;
        active_next   = active_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        waiters_next  = waiters_reg;
        status_next   = status_reg;
        woken_id_next = woken_id_reg;
        last_next     = last_reg;
        load          = 1'b0;
        wr_en         = 1'b0;

        if (cmd.exec)
        begin
            load          = 1'b1;
            status_next   = ST_OK;
            woken_id_next = '0;
            last_next     = 1'b1;
            if (action_reg == ACT_CREATE)
            begin
                count_next   = $signed({{(CNT_W-INIT_W){1'b0}}, init_value_reg});
                active_next  = 1'b1;
                head_next    = '0;
                tail_next    = '0;
                waiters_next = '0;
            end
            else if (!active_reg)
            begin
                status_next = ST_INACTIVE;
            end
            else
            begin
                case (action_reg)
                    ACT_DOWN:
                    begin
                        if (count_le0 && q_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            count_next = count_reg - COUNT_ONE;
                            if (count_le0)
                            begin
                                wr_en         = 1'b1;
                                tail_next     = tail_inc;
                                waiters_next  = waiters_reg + W_ONE;
                                status_next   = ST_BLOCKED;
                                woken_id_next = task_id_reg;
                            end
                        end
                    end
                    ACT_UP:
                    begin
                        count_next = count_up;
                        if (up_le0 && !q_empty)
                        begin
                            head_next     = head_inc;
                            waiters_next  = waiters_reg - W_ONE;
                            status_next   = ST_WOKEN;
                            woken_id_next = rd_data_reg;
                        end
                    end
                    ACT_DESTROY:
                    begin
                        active_next = 1'b0;
                        // With waiters queued, the drain loop produces the words.
                        load = q_empty;
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
        end
        else if (cmd.drain)
        begin
            load          = 1'b1;
            status_next   = ST_WOKEN;
            woken_id_next = rd_data_reg;
            last_next     = stat.drain_last;
            waiters_next  = waiters_reg - W_ONE;
            if (stat.drain_last)
            begin
                head_next = '0;
                tail_next = '0;
            end
            else
            begin
                head_next = head_inc;
            end
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            active_reg    <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            waiters_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            active_reg    <= active_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            waiters_reg   <= waiters_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            action_reg     <= action;
            task_id_reg    <= task_id;
            init_value_reg <= init_value;
        end
        status_reg   <= status_next;
        woken_id_reg <= woken_id_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wait_mem[tail_reg] <= task_id_reg;
        end
        rd_data_reg <= wait_mem[head_next];
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign woken_id  = woken_id_reg;
    assign last      = last_reg;

endmodule

// ----- design/counting_semaphore_wait_queue.sv -----
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue
// Counting semaphore with a FIFO queue of blocked task ids.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries one word per kernel
// call: action, task_id and init_value. The output channel (out_valid/
// out_ready) returns result words of status, woken_id and last. Every input
// word yields at least one result word; last marks the final one.
// Create, down and up take two steps per word: one to latch the word and
// one to execute it against the count and the wait queue, after which the
// result sits in the output register. A destroy with N waiters first runs an
// execute step that writes no result, then drains the queue at one waiter
// per cycle unless the receiver stalls. The queue is a single-port-write,
// registered-read memory whose read address follows the next head, which
// sets the one-pop-per-cycle drain rate. One word is processed at a time;
// in_ready is high only while the sequencer is idle, and a finished result
// may still be waiting in the output register while the next word is taken.
// If the receiver stalls, the output register holds its word and the block
// stops at the point where it would write the next result.
// Reset leaves the semaphore inactive, the count at zero and the queue empty.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue
    import csq_pkg::*;
#(
    parameter int WAIT_DEPTH = DEF_WAIT_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ACT_W-1:0]  action,
    input  logic [ID_W-1:0]   task_id,
    input  logic [INIT_W-1:0] init_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [STAT_W-1:0] status,
    output logic [ID_W-1:0]   woken_id,
    output logic              last
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // The sequencer decides when a word is taken, executed or drained.
    csq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the count, the queue and the result register.
    csq_dp #(
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .action     (action),
        .task_id    (task_id),
        .init_value (init_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .woken_id   (woken_id),
        .last       (last)
    );

    // Only one word is in flight: right after a word is taken, input closes.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken again while a word is in flight");

    // The drain loop never pops from an empty queue.
    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drain |-> !stat.queue_empty)
        else $error("drain issued on empty wait queue");

    // An inactive result is a single word with no task id.
    a_inactive_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_INACTIVE)) |-> (last && (woken_id == '0)))
        else $error("inactive result carries an id or is not last");

endmodule
